// ===== hw/rtl/swc_pkg.sv =====
// Shared types, constants and lookup functions of the square-wave channel.
// No dependencies; included first by every other file of the block.
package swc_pkg;

  localparam int ACTION_W = 3;
  localparam int DATA_W   = 8;
  localparam int VOL_W    = 4;
  localparam int PERIOD_W = 16;
  localparam int LEN_W    = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'h07FF;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd8;
  localparam logic [PERIOD_W-1:0] HIGH_BYTE  = 16'hFF00;
  localparam logic [PERIOD_W-1:0] LOW_BYTE   = 16'h00FF;
  localparam logic [VOL_W-1:0]    LEVEL_FULL = 4'd15;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CTRL    = 3'd0,
    ACT_SWEEP   = 3'd1,
    ACT_TIMER_LO = 3'd2,
    ACT_TIMER_HI = 3'd3,
    ACT_ENABLE  = 3'd4,
    ACT_TICK    = 3'd5,
    ACT_QUARTER = 3'd6,
    ACT_HALF    = 3'd7
  } action_t;

  // Input register contents handed to the core.
  typedef struct packed {
    logic                valid;
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data;
  } swc_stage_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] period_count;
    logic [2:0]          duty_step;
    logic [1:0]          duty_mode;
    logic [LEN_W-1:0]    length_count;
    logic                length_enable;
    logic                chan_enabled;
    logic                env_loop;
    logic                env_use;
    logic [3:0]          env_param;
    logic                env_start;
    logic [3:0]          env_level;
    logic [3:0]          env_divider;
    logic                sweep_on;
    logic [3:0]          sweep_reload_period;
    logic                sweep_down;
    logic [2:0]          sweep_shift_amount;
    logic                sweep_restart;
    logic [3:0]          sweep_divider;
  } swc_state_t;

  // Duty patterns, bit n is sequencer step n.
  localparam logic [7:0] DUTY_SEQ [4] = '{
    8'b0000_0010,
    8'b0000_0110,
    8'b0001_1110,
    8'b1111_1001
  };

  function automatic logic duty_bit(logic [1:0] mode, logic [2:0] step);
    return DUTY_SEQ[mode][step];
  endfunction

  function automatic logic [LEN_W-1:0] length_lookup(logic [4:0] idx);
    logic [LEN_W-1:0] v;
    case (idx)
      5'd0:  v = 8'd10;
      5'd1:  v = 8'd254;
      5'd2:  v = 8'd20;
      5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;
      5'd5:  v = 8'd4;
      5'd6:  v = 8'd80;
      5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;
      5'd9:  v = 8'd8;
      5'd10: v = 8'd60;
      5'd11: v = 8'd10;
      5'd12: v = 8'd14;
      5'd13: v = 8'd12;
      5'd14: v = 8'd26;
      5'd15: v = 8'd14;
      5'd16: v = 8'd12;
      5'd17: v = 8'd16;
      5'd18: v = 8'd24;
      5'd19: v = 8'd18;
      5'd20: v = 8'd48;
      5'd21: v = 8'd20;
      5'd22: v = 8'd96;
      5'd23: v = 8'd22;
      5'd24: v = 8'd192;
      5'd25: v = 8'd24;
      5'd26: v = 8'd72;
      5'd27: v = 8'd26;
      5'd28: v = 8'd16;
      5'd29: v = 8'd28;
      5'd30: v = 8'd32;
      5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/swc_ifs.sv =====
// Valid/ready channel interfaces of the square-wave channel: items, results, config.
// Depends on swc_pkg.
interface swc_in_if import swc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   data;
  modport source (output valid, action, data, input ready);
  modport sink   (input valid, action, data, output ready);
endinterface

interface swc_out_if import swc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VOL_W-1:0] volume;
  logic             length_active;
  modport source (output valid, volume, length_active, input ready);
  modport sink   (input valid, volume, length_active, output ready);
endinterface

interface swc_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/square_wave_channel_top.sv =====
// Top level of the square-wave sound channel: input register, core, result register.
// Depends on swc_pkg, swc_ifs, swc_in_stage and swc_core.

// One pulse channel of a console audio unit. Every transaction on "item" is
// either a register write (control, sweep, timer low, timer high, enable; the
// byte rides in data, bit 0 of data is the enable) or a clock event (timer
// tick, quarter-frame tick, half-frame tick; data ignored). Each item gives
// exactly one result transaction on "result": the 4-bit volume after the item
// has acted (zero when disabled, length expired, duty step low or the period
// outside 8..0x7FF) and the length-active status bit. The block takes one item
// per clock cycle for as long as results are taken; an item passes through the
// input register, then the state update goes straight into the result register,
// and the single result register paired with the input register lets a new item
// in while a result waits. The "cfg" channel writes first_channel (data bit),
// which makes a sweep decrease subtract one extra; it is always ready and is
// to be written only while no item is in flight.
module square_wave_channel_top import swc_pkg::*; (
  input logic     clk,
  input logic     rst,
  swc_in_if.sink  item,
  swc_out_if.source result,
  swc_cfg_if.sink cfg
);

  swc_stage_t       stage;
  logic             drain_ok;   // result register can take a new value
  logic             fire;       // core consumes the staged item this cycle
  logic             first_channel;
  logic             res_valid;
  logic [VOL_W-1:0] res_volume;
  logic             res_length_active;
  logic [VOL_W-1:0] core_volume;
  logic             core_length_active;

  assign drain_ok = !res_valid || result.ready;
  assign fire     = stage.valid && drain_ok;

  // config register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_channel <= 1'b0;
    end else if (cfg.valid) begin
      first_channel <= cfg.data;
    end
  end

  swc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .drain_ok (drain_ok),
    .stage    (stage)
  );

  swc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .action        (stage.action),
    .data          (stage.data),
    .first_channel (first_channel),
    .volume        (core_volume),
    .length_active (core_length_active)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (drain_ok) begin
      res_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_volume        <= core_volume;
      res_length_active <= core_length_active;
    end
  end

  assign result.valid         = res_valid;
  assign result.volume        = res_volume;
  assign result.length_active = res_length_active;

  // A stalled result with an item staged must hold off new items.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && res_valid && !result.ready) |-> !item.ready)
    else $error("item accepted while pipeline is full");

  // Sound only comes out while the length counter runs.
  a_volume_needs_length: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_volume != '0) |-> res_length_active)
    else $error("nonzero volume with length counter at zero");

  // Reset empties both registers.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!res_valid && !stage.valid))
    else $error("pipeline not empty after reset");

  // A staged item moves on whenever the result side frees up.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && drain_ok) |=> res_valid)
    else $error("staged item lost");

endmodule

// ===== hw/rtl/swc_in_stage.sv =====
// Input register of the square-wave channel; holds one item for the core.
// Depends on swc_pkg and swc_ifs.
module swc_in_stage import swc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  swc_in_if.sink     item,
  input  logic       drain_ok,
  output swc_stage_t stage
);

  logic                valid;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   data;

  assign item.ready = !valid || drain_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      action <= item.action;
      data   <= item.data;
    end
  end

  assign stage = '{valid: valid, action: action, data: data};

endmodule

// ===== hw/rtl/swc_core.sv =====
// Channel state and its single-pass update: timer, duty, envelope, sweep, length.
// Depends on swc_pkg.
module swc_core import swc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [ACTION_W-1:0] action,
  input  logic [DATA_W-1:0]   data,
  input  logic             first_channel,
  output logic [VOL_W-1:0] volume,
  output logic             length_active
);

  swc_state_t st, st_next;

  // clock-event pieces, all from current state
  logic [3:0]          env_level_clk, env_div_clk;
  logic                env_start_clk;
  logic [PERIOD_W-1:0] sweep_delta, sweep_result, period_clk;
  logic                sweep_apply;
  logic [3:0]          sweep_div_clk;
  logic [LEN_W-1:0]    length_clk;

  always_comb begin
    env_level_clk = st.env_level;
    env_div_clk   = st.env_divider;
    env_start_clk = 1'b0;
    if (st.env_start) begin
      env_level_clk = LEVEL_FULL;
      env_div_clk   = st.env_param;
    end else if (st.env_divider != 4'd0) begin
      env_div_clk = st.env_divider - 4'd1;
    end else begin
      if (st.env_level != 4'd0) begin
        env_level_clk = st.env_level - 4'd1;
      end else if (st.env_loop) begin
        env_level_clk = LEVEL_FULL;
      end
      env_div_clk = st.env_param;
    end
  end

  always_comb begin
    sweep_delta = st.period >> st.sweep_shift_amount;
    if (st.sweep_down) begin
      sweep_result = st.period - sweep_delta - {15'd0, first_channel};
    end else begin
      sweep_result = st.period + sweep_delta;
    end
    sweep_apply = st.sweep_on && (st.sweep_divider == 4'd0) &&
                  (st.sweep_shift_amount != 3'd0);
    period_clk  = sweep_apply ? sweep_result : st.period;
    if (st.sweep_restart || st.sweep_divider == 4'd0) begin
      sweep_div_clk = st.sweep_reload_period;
    end else begin
      sweep_div_clk = st.sweep_divider - 4'd1;
    end
    if (st.length_enable && st.length_count != '0) begin
      length_clk = st.length_count - 8'd1;
    end else begin
      length_clk = st.length_count;
    end
  end

  always_comb begin
    st_next = st;
    case (action_t'(action))
      ACT_CTRL: begin
        st_next.duty_mode     = data[7:6];
        st_next.length_enable = ~data[5];
        st_next.env_loop      = data[5];
        st_next.env_use       = ~data[4];
        st_next.env_param     = data[3:0];
        st_next.env_start     = 1'b1;
      end
      ACT_SWEEP: begin
        st_next.sweep_on            = data[7];
        st_next.sweep_reload_period = {1'b0, data[6:4]} + 4'd1;
        st_next.sweep_down          = data[3];
        st_next.sweep_shift_amount  = data[2:0];
        st_next.sweep_restart       = 1'b1;
      end
      ACT_TIMER_LO: begin
        st_next.period = (st.period & HIGH_BYTE) | {8'h00, data};
      end
      ACT_TIMER_HI: begin
        if (st.chan_enabled) begin
          st_next.length_count = length_lookup(data[7:3]);
        end
        st_next.period    = (st.period & LOW_BYTE) | {5'd0, data[2:0], 8'h00};
        st_next.env_start = 1'b1;
        st_next.duty_step = 3'd0;
      end
      ACT_ENABLE: begin
        st_next.chan_enabled = data[0];
        if (!data[0]) begin
          st_next.length_count = '0;
        end
      end
      ACT_TICK: begin
        if (st.period_count == '0) begin
          st_next.period_count = st.period;
          st_next.duty_step    = st.duty_step + 3'd1;
        end else begin
          st_next.period_count = st.period_count - 16'd1;
        end
      end
      ACT_QUARTER: begin
        st_next.env_level   = env_level_clk;
        st_next.env_divider = env_div_clk;
        st_next.env_start   = env_start_clk;
      end
      ACT_HALF: begin
        st_next.env_level     = env_level_clk;
        st_next.env_divider   = env_div_clk;
        st_next.env_start     = env_start_clk;
        st_next.period        = period_clk;
        st_next.sweep_divider = sweep_div_clk;
        st_next.sweep_restart = 1'b0;
        st_next.length_count  = length_clk;
      end
      default: st_next = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Result reflects the state after the item acts.
  always_comb begin
    length_active = (st_next.length_count != '0);
    if (!st_next.chan_enabled || !length_active ||
        !duty_bit(st_next.duty_mode, st_next.duty_step) ||
        st_next.period < PERIOD_MIN || st_next.period > PERIOD_MAX) begin
      volume = '0;
    end else begin
      volume = st_next.env_use ? st_next.env_level : st_next.env_param;
    end
  end

endmodule

// ===== dv/square_wave_channel_top_test.sv =====
// Self-checking testbench of the square-wave sound channel (square_wave_channel_top).
// Holds a scoreboard class with its own channel predictor; depends on swc_pkg and swc_ifs.
`timescale 1ns / 100ps

module square_wave_channel_top_test;
  import swc_pkg::*;

  // Expected level and status for one item.
  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic             active;
  } level_t;

  // Scoreboard. It tracks the channel state on every accepted item, queues the
  // level that item must produce and checks results in order.
  class pulse_level_board;
    level_t level_due[$];
    int     errors;
    int     checked;

    bit first_chan;

    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] period_cnt;
    logic [2:0]          duty_step;
    logic [1:0]          duty_mode;
    logic [LEN_W-1:0]    len_count;
    logic                len_enable;
    logic                chan_on;
    logic                env_loop;
    logic                env_use;
    logic [3:0]          env_param;
    logic                env_start;
    logic [3:0]          env_level;
    logic [3:0]          env_div;
    logic                sweep_on;
    logic [3:0]          sweep_reload;
    logic                sweep_down;
    logic [2:0]          sweep_shift;
    logic                sweep_restart;
    logic [3:0]          sweep_div;

    // Bit n of each pattern is sequencer step n.
    logic [7:0] duty_wave [4] = '{8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001};
    logic [7:0] length_table [32] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    function new();
      errors = 0;
      checked = 0;
      first_chan = 0;
      period = '0;
      period_cnt = '0;
      duty_step = '0;
      duty_mode = '0;
      len_count = '0;
      len_enable = 0;
      chan_on = 0;
      env_loop = 0;
      env_use = 0;
      env_param = '0;
      env_start = 0;
      env_level = '0;
      env_div = '0;
      sweep_on = 0;
      sweep_reload = '0;
      sweep_down = 0;
      sweep_shift = '0;
      sweep_restart = 0;
      sweep_div = '0;
    endfunction

    function void set_first(bit v);
      first_chan = v;
    endfunction

    function int pending();
      return level_due.size();
    endfunction

    function void step_envelope();
      if (env_start) begin
        env_level = LEVEL_FULL;
        env_div = env_param;
        env_start = 0;
      end else if (env_div != 0) begin
        env_div = env_div - 4'd1;
      end else begin
        if (env_level != 0) env_level = env_level - 4'd1;
        else if (env_loop) env_level = LEVEL_FULL;
        env_div = env_param;
      end
    endfunction

    // Sweep adjustment wraps at 16 bits; no overflow mute.
    function void adjust_period();
      logic [PERIOD_W-1:0] delta;
      if (sweep_shift == 0) return;
      delta = period >> sweep_shift;
      if (sweep_down) period = period - delta - {15'd0, first_chan};
      else period = period + delta;
    endfunction

    function void step_sweep();
      if (sweep_restart) begin
        if (sweep_on && sweep_div == 0) adjust_period();
        sweep_div = sweep_reload;
        sweep_restart = 0;
      end else if (sweep_div != 0) begin
        sweep_div = sweep_div - 4'd1;
      end else begin
        if (sweep_on) adjust_period();
        sweep_div = sweep_reload;
      end
    endfunction

    function logic [VOL_W-1:0] level_now();
      if (!chan_on || len_count == 0) return '0;
      if (!duty_wave[duty_mode][duty_step]) return '0;
      if (period < PERIOD_MIN || period > PERIOD_MAX) return '0;
      return env_use ? env_level : env_param;
    endfunction

    function void note_item(action_t act, logic [DATA_W-1:0] d);
      level_t lv;
      case (act)
        ACT_CTRL: begin
          duty_mode = d[7:6];
          len_enable = ~d[5];
          env_loop = d[5];
          env_use = ~d[4];
          env_param = d[3:0];
          env_start = 1;
        end
        ACT_SWEEP: begin
          sweep_on = d[7];
          sweep_reload = {1'b0, d[6:4]} + 4'd1;
          sweep_down = d[3];
          sweep_shift = d[2:0];
          sweep_restart = 1;
        end
        ACT_TIMER_LO: period = (period & HIGH_BYTE) | {8'd0, d};
        ACT_TIMER_HI: begin
          // length only loads while the channel is enabled
          if (chan_on) len_count = length_table[d[7:3]];
          period = (period & LOW_BYTE) | {5'd0, d[2:0], 8'd0};
          env_start = 1;
          duty_step = '0;
        end
        ACT_ENABLE: begin
          chan_on = d[0];
          if (!d[0]) len_count = '0;
        end
        ACT_TICK: begin
          if (period_cnt == 0) begin
            period_cnt = period;
            duty_step = duty_step + 3'd1;
          end else begin
            period_cnt = period_cnt - 16'd1;
          end
        end
        ACT_QUARTER: step_envelope();
        default: begin
          step_envelope();
          step_sweep();
          if (len_enable && len_count != 0) len_count = len_count - 8'd1;
        end
      endcase
      lv.volume = level_now();
      lv.active = (len_count != 0);
      level_due.push_back(lv);
    endfunction

    function void check_level(logic [VOL_W-1:0] vol, logic act);
      level_t lv;
      checked++;
      if (level_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual volume %0d active %0b",
                 $time, vol, act);
        errors++;
        return;
      end
      lv = level_due.pop_front();
      if (vol !== lv.volume) begin
        $display("%0t: volume mismatch, expected %0d, actual %0d", $time, lv.volume, vol);
        errors++;
      end
      if (act !== lv.active) begin
        $display("%0t: length_active mismatch, expected %0b, actual %0b",
                 $time, lv.active, act);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  swc_in_if  item_ch ();
  swc_out_if result_ch ();
  swc_cfg_if cfg_ch ();

  square_wave_channel_top u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  pulse_level_board sb = new();

  int items_sent = 0;  // counted by the sender on each accepted transaction
  int burst_left = 0;  // items left in the current sender burst
  bit rx_holding = 0;  // receiver is in its long hold-off
  bit hold_done  = 0;

  always #2 clk = ~clk;

  // Monitor: all three channels sampled at the edge, before any new drive lands.
  // Results are checked before the item of the same edge is noted; each item passes the
  // input and result registers, so a result never belongs to an item taken at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready)
        sb.check_level(result_ch.volume, result_ch.length_active);
      if (item_ch.valid && item_ch.ready)
        sb.note_item(action_t'(item_ch.action), item_ch.data);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_first(cfg_ch.data);
    end
  end

  // Receiver: stalls in phases of random length, each with its own pattern.
  // Once, well into the run, it holds ready low for a long stretch so that the
  // input register and result register both fill and the block stalls its input.
  initial begin
    int mode;
    int span;
    int tick_cnt;
    result_ch.ready <= 1'b0;
    tick_cnt = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        tick_cnt++;
        if (!hold_done && items_sent >= 450) begin
          rx_holding = 1;
          result_ch.ready <= 1'b0;
          repeat (80) @(posedge clk);
          rx_holding = 0;
          hold_done = 1;
        end
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= (tick_cnt % 4 == 0);
          default: result_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Sender: offers one item and waits for the transaction. Bursts of random
  // length with random gaps between them; valid stays high inside a burst.
  // No gaps while the receiver holds off, so the block really backs up.
  task automatic push_item(input action_t act, input logic [DATA_W-1:0] d);
    if (burst_left == 0 && !rx_holding) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    item_ch.valid  <= 1'b1;
    item_ch.action <= act;
    item_ch.data   <= d;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drops valid, waits until every accepted item has its result, then lets the block idle.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sb.checked < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_first_channel(input bit v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Full setup of a note: enable, control, sweep, both timer bytes.
  // Mostly short periods so the duty sequencer moves often.
  task automatic play_note();
    logic [DATA_W-1:0] d;
    d = DATA_W'($urandom_range(0, 255));
    d[0] = 1'b1;
    push_item(ACT_ENABLE, d);
    push_item(ACT_CTRL, DATA_W'($urandom_range(0, 255)));
    push_item(ACT_SWEEP, DATA_W'($urandom_range(0, 255)));
    d = DATA_W'(($urandom_range(0, 1) != 0) ? $urandom_range(8, 40)
                                             : $urandom_range(0, 255));
    push_item(ACT_TIMER_LO, d);
    d = DATA_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) d[2:0] = 3'd0;
    push_item(ACT_TIMER_HI, d);
  endtask

  // One random item, weighted toward timer ticks and frame ticks.
  task automatic push_random();
    int r;
    logic [DATA_W-1:0] d;
    action_t act;
    r = $urandom_range(0, 99);
    d = DATA_W'($urandom_range(0, 255));
    if (r < 40) act = ACT_TICK;
    else if (r < 50) act = ACT_QUARTER;
    else if (r < 62) act = ACT_HALF;
    else if (r < 70) act = ACT_CTRL;
    else if (r < 77) act = ACT_SWEEP;
    else if (r < 84) act = ACT_TIMER_LO;
    else if (r < 92) begin
      act = ACT_TIMER_HI;
      if ($urandom_range(0, 3) != 0) d[2:0] = 3'd0;
    end else begin
      act = ACT_ENABLE;
      if ($urandom_range(0, 4) != 0) d[0] = 1'b1;
    end
    push_item(act, d);
  endtask

  task automatic random_phase(input int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 29) == 0) begin
        play_note();
        n += 5;
      end else begin
        push_random();
        n++;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_ch.valid  <= 1'b0;
    item_ch.action <= ACT_TICK;
    item_ch.data   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the extra-one subtraction selected.
    write_first_channel(1'b1);
    push_item(ACT_TICK, 8'hFF);       // tick with period zero, data ignored
    push_item(ACT_TIMER_HI, 8'hFF);   // disabled: no length load, period bits taken
    push_item(ACT_ENABLE, 8'hFF);     // upper bits ignored
    push_item(ACT_CTRL, 8'hFF);       // duty 3, halt, constant level 15
    push_item(ACT_TIMER_LO, 8'hFF);   // period at its top, 0x7FF
    push_item(ACT_TIMER_HI, 8'h0F);   // longest length, audible
    push_item(ACT_SWEEP, 8'h00);      // sweep off, zero shift
    push_item(ACT_HALF, 8'h00);       // halted length stays
    push_item(ACT_QUARTER, 8'hAA);
    push_item(ACT_CTRL, 8'h00);       // duty 0, decaying envelope, length counts
    push_item(ACT_TICK, 8'h00);
    push_item(ACT_TICK, 8'h55);
    push_item(ACT_TIMER_HI, 8'h08);   // period down to 0x0FF
    push_item(ACT_TIMER_LO, 8'h07);   // period below 8: muted
    push_item(ACT_SWEEP, 8'hF9);      // on, slowest divider, down, shift 1
    push_item(ACT_HALF, 8'hFF);
    push_item(ACT_HALF, 8'h00);
    push_item(ACT_TIMER_LO, 8'h00);   // period zero
    push_item(ACT_SWEEP, 8'h89);      // on, down, shift 1; divider not at zero, so period stays zero
    push_item(ACT_HALF, 8'h00);
    push_item(ACT_SWEEP, 8'h81);      // up, shift 1: a zero period stays zero
    push_item(ACT_HALF, 8'h00);
    push_item(ACT_ENABLE, 8'h00);     // disable clears the length
    push_item(ACT_ENABLE, 8'h01);
    push_item(ACT_QUARTER, 8'h00);
    settle();

    // Random phases, alternating the sweep subtraction mode.
    for (int ph = 0; ph < 5; ph++) begin
      write_first_channel(ph % 2 == 1);
      random_phase(190);
      settle();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived, expected volume %0d, actual none",
               $time, sb.pending(), sb.level_due[0].volume);
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/swc_pkg.sv
hw/rtl/swc_ifs.sv
hw/rtl/swc_in_stage.sv
hw/rtl/swc_core.sv
hw/rtl/square_wave_channel_top.sv
dv/square_wave_channel_top_test.sv
